### src/pidaw_pkg.sv
`timescale 1ns / 1ps

package pidaw_pkg;

   localparam int ADDR_W    = 5;
   localparam int OPA_W     = 48;
   localparam int PROD_W    = 80;
   localparam int DIV_STEPS = 48;
   localparam int CNT_W     = 6;

   localparam logic [1:0] KIND_COMPUTE = 2'd0;
   localparam logic [1:0] KIND_CLEAR   = 2'd1;
   localparam logic [1:0] KIND_RECLAMP = 2'd2;

   localparam logic [2:0] REG_GAIN_P     = 3'd0;
   localparam logic [2:0] REG_GAIN_I     = 3'd1;
   localparam logic [2:0] REG_GAIN_D     = 3'd2;
   localparam logic [2:0] REG_LIMIT_LOW  = 3'd3;
   localparam logic [2:0] REG_LIMIT_HIGH = 3'd4;

   localparam logic signed [31:0] LIMIT_LOW_RESET  = 32'shFF00_0000;
   localparam logic signed [31:0] LIMIT_HIGH_RESET = 32'sh0100_0000;

   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] target;
      logic signed [31:0] measured;
      logic [31:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               clamped;
      logic               bad_step;
   } rsp_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

### src/pidaw_muldiv.sv
`timescale 1ns / 1ps

module pidaw_muldiv (
   input  logic                           clock,
   input  logic                           reset,
   input  pidaw_pkg::unit_cmd_type        cmd,
   input  logic [pidaw_pkg::OPA_W-1:0]    a_mag,
   input  logic [31:0]                    b_mag,
   output pidaw_pkg::unit_stat_type       stat,
   output logic [pidaw_pkg::PROD_W-1:0]   result
);
   import pidaw_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OPA_W-1:0]  a_ff, a_in;
   logic [31:0]       b_ff, b_in;
   logic [63:0]       prod_ff, prod_in;
   logic [PROD_W-1:0] res_ff, res_in;
   logic [31:0]       rem_ff, rem_in;

   logic [31:0]       mul_a;
   logic [63:0]       mul_p;
   logic [33:0]       trial;
   logic              take;

   // product in two partial products: low 32 bits of a, then the upper 16
   assign mul_a = (cnt_ff == '0) ? a_ff[31:0] : {16'd0, a_ff[OPA_W-1:32]};
   assign mul_p = 64'(mul_a) * 64'(b_ff);

   // restoring division, one quotient bit per cycle, dividend shifted out of a_ff
   assign trial = {1'b0, rem_ff, a_ff[OPA_W-1]} - {2'b00, b_ff};
   assign take  = ~trial[33];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1;
            op_in   = cmd.op;
            cnt_in  = '0;
            a_in    = a_mag;
            b_in    = b_mag;
            rem_in  = '0;
         end
      end else begin
         unique case (op_ff)
            OP_MUL: begin
               if (cnt_ff == '0) begin
                  prod_in = mul_p;
                  cnt_in  = CNT_W'(1);
               end else if (cnt_ff == CNT_W'(1)) begin
                  res_in  = {16'd0, prod_ff};
                  prod_in = mul_p;
                  cnt_in  = CNT_W'(2);
               end else begin
                  res_in  = res_ff + {prod_ff[47:0], 32'd0};
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            OP_DIV: begin
               a_in   = {a_ff[OPA_W-2:0], take};
               rem_in = take ? trial[31:0] : {rem_ff[30:0], a_ff[OPA_W-1]};
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  res_in  = {32'd0, a_ff[OPA_W-2:0], take};
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
   end

   assign stat   = '{busy: busy_ff, done: done_ff};
   assign result = res_ff;

endmodule

### src/pid_antiwindup_controller.sv
// one shared multiply/divide unit does every product and division, one operation at a time
// throughput: one transaction at a time, the next is accepted once the result is registered
// reset: synchronous, gains zero, limits -256.0 and +256.0, integral and last measurement
//   zero, first-step flag set
`timescale 1ns / 1ps

module pid_antiwindup_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pidaw_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pidaw_pkg::rsp_type            rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pidaw_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import pidaw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_IE,
      ST_CLAMP,
      ST_MUL_CHK,
      ST_DIV_CLAMP,
      ST_POST_CLAMP,
      ST_MUL_I,
      ST_DERIV,
      ST_DIV_DER,
      ST_MUL_D,
      ST_SUM,
      ST_LIMIT,
      ST_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic signed [31:0] gain_p_ff, gain_p_in;
   logic signed [31:0] gain_i_ff, gain_i_in;
   logic signed [31:0] gain_d_ff, gain_d_in;
   logic signed [31:0] limit_low_ff, limit_low_in;
   logic signed [31:0] limit_high_ff, limit_high_in;
   logic [1:0]         kind_ff, kind_in;
   logic signed [31:0] meas_ff, meas_in;
   logic [31:0]        dt_ff, dt_in;
   logic [32:0]        err_mag_ff, err_mag_in;
   logic               err_neg_ff, err_neg_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [31:0] last_ff, last_in;
   logic               first_ff, first_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [63:0] i_ff, i_in;
   logic signed [63:0] d_ff, d_in;
   logic signed [63:0] sum_ff, sum_in;
   unit_cmd_type       cmd_ff, cmd_in;
   logic [OPA_W-1:0]   opa_ff, opa_in;
   logic [31:0]        opb_ff, opb_in;
   logic               neg_ff, neg_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   unit_stat_type      unit_stat;
   logic [PROD_W-1:0]  unit_res;

   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        gp_mag, ki_mag, gd_mag, lo_mag, hi_mag;
   logic               ki_zero;
   logic [47:0]        acc_mag;
   logic signed [32:0] req_err;
   logic [32:0]        req_err_mag;
   logic [63:0]        prod_mag;
   logic signed [63:0] prod_val;
   logic [47:0]        quo;
   logic signed [47:0] clamp_val;
   logic signed [49:0] ie_sum;
   logic signed [47:0] acc_sat;
   logic signed [63:0] lo64, hi64;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic signed [63:0] pi_sum;
   logic signed [64:0] full_sum;
   logic signed [63:0] sum_sat;

   pidaw_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .a_mag  (opa_ff),
      .b_mag  (opb_ff),
      .stat   (unit_stat),
      .result (unit_res)
   );

   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_GAIN_P:     csr_prdata = gain_p_ff;
         REG_GAIN_I:     csr_prdata = gain_i_ff;
         REG_GAIN_D:     csr_prdata = gain_d_ff;
         REG_LIMIT_LOW:  csr_prdata = limit_low_ff;
         REG_LIMIT_HIGH: csr_prdata = limit_high_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // sign-magnitude operands for the shared unit
   assign gp_mag  = gain_p_ff[31] ? (~gain_p_ff + 32'd1) : gain_p_ff;
   assign ki_mag  = gain_i_ff[31] ? (~gain_i_ff + 32'd1) : gain_i_ff;
   assign gd_mag  = gain_d_ff[31] ? (~gain_d_ff + 32'd1) : gain_d_ff;
   assign lo_mag  = limit_low_ff[31] ? (~limit_low_ff + 32'd1) : limit_low_ff;
   assign hi_mag  = limit_high_ff[31] ? (~limit_high_ff + 32'd1) : limit_high_ff;
   assign ki_zero = (gain_i_ff == '0);
   assign acc_mag = acc_ff[47] ? (~acc_ff + 48'd1) : acc_ff;

   assign req_err     = {req_data.target[31], req_data.target}
                      - {req_data.measured[31], req_data.measured};
   assign req_err_mag = req_err[32] ? (~req_err + 33'd1) : req_err;

   // product scaled back by 16 bits, truncated toward zero
   assign prod_mag = unit_res[79:16];
   assign prod_val = neg_ff ? $signed(~prod_mag + 64'd1) : $signed(prod_mag);
   assign quo      = unit_res[47:0];

   always_comb begin
      if (neg_ff) begin
         clamp_val = ~quo + 48'd1;
      end else if (quo[47]) begin
         clamp_val = ACC_MAX;
      end else begin
         clamp_val = quo;
      end
   end

   assign ie_sum = {{2{acc_ff[47]}}, acc_ff} + prod_val[49:0];

   always_comb begin
      if (ie_sum[49:47] == 3'b000 || ie_sum[49:47] == 3'b111) begin
         acc_sat = ie_sum[47:0];
      end else begin
         acc_sat = ie_sum[49] ? ACC_MIN : ACC_MAX;
      end
   end

   assign lo64 = {{32{limit_low_ff[31]}}, limit_low_ff};
   assign hi64 = {{32{limit_high_ff[31]}}, limit_high_ff};

   assign diff     = {meas_ff[31], meas_ff} - {last_ff[31], last_ff};
   assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

   assign pi_sum   = p_ff + i_ff;
   assign full_sum = {pi_sum[63], pi_sum} + {d_ff[63], d_ff};

   always_comb begin
      if (full_sum[64] != full_sum[63]) begin
         sum_sat = full_sum[64] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = full_sum[63:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      limit_low_in  = limit_low_ff;
      limit_high_in = limit_high_ff;
      kind_in       = kind_ff;
      meas_in       = meas_ff;
      dt_in         = dt_ff;
      err_mag_in    = err_mag_ff;
      err_neg_in    = err_neg_ff;
      acc_in        = acc_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      d_in          = d_ff;
      sum_in        = sum_ff;
      cmd_in        = '{start: 1'b0, op: cmd_ff.op};
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_P:     gain_p_in = csr_pwdata;
            REG_GAIN_I:     gain_i_in = csr_pwdata;
            REG_GAIN_D:     gain_d_in = csr_pwdata;
            REG_LIMIT_LOW:  limit_low_in = csr_pwdata;
            REG_LIMIT_HIGH: limit_high_in = csr_pwdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.kind;
               res_in  = '0;
               unique case (req_data.kind)
                  KIND_CLEAR: begin
                     acc_in   = '0;
                     last_in  = '0;
                     first_in = 1'b1;
                     state_in = ST_RESP;
                  end
                  KIND_RECLAMP: begin
                     state_in = ST_CLAMP;
                  end
                  KIND_COMPUTE: begin
                     if (req_data.time_step == '0) begin
                        res_in.drive    = limit_low_ff;
                        res_in.bad_step = 1'b1;
                        state_in        = ST_RESP;
                     end else begin
                        meas_in    = req_data.measured;
                        dt_in      = req_data.time_step;
                        err_mag_in = req_err_mag;
                        err_neg_in = req_err[32];
                        cmd_in     = '{start: 1'b1, op: OP_MUL};
                        opa_in     = {15'd0, req_err_mag};
                        opb_in     = gp_mag;
                        neg_in     = req_err[32] ^ gain_p_ff[31];
                        state_in   = ST_MUL_P;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_MUL_P: begin
            if (unit_stat.done) begin
               p_in     = prod_val;
               cmd_in   = '{start: 1'b1, op: OP_MUL};
               opa_in   = {15'd0, err_mag_ff};
               opb_in   = dt_ff;
               neg_in   = err_neg_ff;
               state_in = ST_MUL_IE;
            end
         end
         ST_MUL_IE: begin
            if (unit_stat.done) begin
               acc_in   = acc_sat;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (ki_zero) begin
               state_in = ST_POST_CLAMP;
            end else begin
               cmd_in   = '{start: 1'b1, op: OP_MUL};
               opa_in   = acc_mag;
               opb_in   = ki_mag;
               neg_in   = acc_ff[47] ^ gain_i_ff[31];
               state_in = ST_MUL_CHK;
            end
         end
         ST_MUL_CHK: begin
            if (unit_stat.done) begin
               // integral term against the limits, upper test first
               if (prod_val > hi64) begin
                  cmd_in   = '{start: 1'b1, op: OP_DIV};
                  opa_in   = {hi_mag, 16'd0};
                  opb_in   = ki_mag;
                  neg_in   = limit_high_ff[31] ^ gain_i_ff[31];
                  state_in = ST_DIV_CLAMP;
               end else if (prod_val < lo64) begin
                  cmd_in   = '{start: 1'b1, op: OP_DIV};
                  opa_in   = {lo_mag, 16'd0};
                  opb_in   = ki_mag;
                  neg_in   = limit_low_ff[31] ^ gain_i_ff[31];
                  state_in = ST_DIV_CLAMP;
               end else begin
                  state_in = ST_POST_CLAMP;
               end
            end
         end
         ST_DIV_CLAMP: begin
            if (unit_stat.done) begin
               acc_in   = clamp_val;
               state_in = ST_POST_CLAMP;
            end
         end
         ST_POST_CLAMP: begin
            if (kind_ff == KIND_RECLAMP) begin
               state_in = ST_RESP;
            end else if (ki_zero) begin
               i_in     = '0;
               state_in = ST_DERIV;
            end else begin
               cmd_in   = '{start: 1'b1, op: OP_MUL};
               opa_in   = acc_mag;
               opb_in   = ki_mag;
               neg_in   = acc_ff[47] ^ gain_i_ff[31];
               state_in = ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            if (unit_stat.done) begin
               i_in     = prod_val;
               state_in = ST_DERIV;
            end
         end
         ST_DERIV: begin
            if (first_ff) begin
               d_in     = '0;
               state_in = ST_SUM;
            end else begin
               // derivative enters negated: sign of the product is that of -diff * kd
               cmd_in   = '{start: 1'b1, op: OP_DIV};
               opa_in   = {diff_mag[31:0], 16'd0};
               opb_in   = dt_ff;
               neg_in   = ~diff[32] ^ gain_d_ff[31];
               state_in = ST_DIV_DER;
            end
         end
         ST_DIV_DER: begin
            if (unit_stat.done) begin
               cmd_in   = '{start: 1'b1, op: OP_MUL};
               opa_in   = quo;
               opb_in   = gd_mag;
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (unit_stat.done) begin
               d_in     = prod_val;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = sum_sat;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            if (sum_ff < lo64) begin
               res_in.drive   = limit_low_ff;
               res_in.clamped = 1'b1;
            end else if (sum_ff > hi64) begin
               res_in.drive   = limit_high_ff;
               res_in.clamped = 1'b1;
            end else begin
               res_in.drive   = sum_ff[31:0];
               res_in.clamped = 1'b0;
            end
            last_in  = meas_ff;
            first_in = 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_low_ff  <= LIMIT_LOW_RESET;
         limit_high_ff <= LIMIT_HIGH_RESET;
         acc_ff        <= '0;
         last_ff       <= '0;
         first_ff      <= 1'b1;
         cmd_ff        <= '{start: 1'b0, op: OP_MUL};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         limit_low_ff  <= limit_low_in;
         limit_high_ff <= limit_high_in;
         acc_ff        <= acc_in;
         last_ff       <= last_in;
         first_ff      <= first_in;
         cmd_ff        <= cmd_in;
         rsp_valid_ff  <= rsp_valid_in;
         kind_ff       <= kind_in;
         meas_ff       <= meas_in;
         dt_ff         <= dt_in;
         err_mag_ff    <= err_mag_in;
         err_neg_ff    <= err_neg_in;
         p_ff          <= p_in;
         i_ff          <= i_in;
         d_ff          <= d_in;
         sum_ff        <= sum_in;
         opa_ff        <= opa_in;
         opb_ff        <= opb_in;
         neg_ff        <= neg_in;
         res_ff        <= res_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_unit_free: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.start |-> !unit_stat.busy)
      else $error("muldiv unit started while busy");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> (state_ff == ST_MUL_P || state_ff == ST_MUL_IE ||
                          state_ff == ST_MUL_CHK || state_ff == ST_DIV_CLAMP ||
                          state_ff == ST_MUL_I || state_ff == ST_DIV_DER ||
                          state_ff == ST_MUL_D))
      else $error("muldiv result arrived with no operation pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted transaction did not start processing");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response state");

endmodule
